@@ design/cxr_pkg.sv @@
package cxr_pkg;

	// fixed point and port sizes
	localparam int FRAC_BITS = 16;
	localparam int OUT_BITS  = 8;
	localparam int IN_W      = 17;
	localparam int OUT_W     = 8;
	localparam int BRT_W     = 8;

	// srgb matrix coefficients, ten-thousandths rounded to Q(FRAC_BITS)
	localparam longint K_RX = ((longint'(32406) << FRAC_BITS) + 5000) / 10000;
	localparam longint K_RY = ((longint'(15372) << FRAC_BITS) + 5000) / 10000;
	localparam longint K_RZ = ((longint'(4986) << FRAC_BITS) + 5000) / 10000;
	localparam longint K_GX = ((longint'(9689) << FRAC_BITS) + 5000) / 10000;
	localparam longint K_GY = ((longint'(18758) << FRAC_BITS) + 5000) / 10000;
	localparam longint K_GZ = ((longint'(415) << FRAC_BITS) + 5000) / 10000;
	localparam longint K_BX = ((longint'(557) << FRAC_BITS) + 5000) / 10000;
	localparam longint K_BY = ((longint'(2040) << FRAC_BITS) + 5000) / 10000;
	localparam longint K_BZ = ((longint'(10570) << FRAC_BITS) + 5000) / 10000;

	// datapath widths
	localparam int KW = FRAC_BITS + 3;
	localparam int ZW = ((IN_W > FRAC_BITS + 1) ? IN_W : FRAC_BITS + 1) + 2;
	localparam int PW = ZW + KW;
	localparam int SW = PW + 2;
	localparam int CW = SW - 1;
	localparam int NW = FRAC_BITS + 1;

	// output scaling
	localparam longint OUT_FULL = (longint'(1) << OUT_BITS) - 1;
	localparam longint HALF_DEN = longint'(255) << (FRAC_BITS - 1);
	localparam int PB_W = NW + BRT_W;
	localparam int AW   = PB_W + OUT_BITS + 1;
	localparam int TW   = AW - FRAC_BITS;
	localparam int RECIP_SH = 16;
	localparam longint RECIP = 257;

	// pipeline depth
	localparam int MAT_STG = 3;
	localparam int DIV_STG = NW;
	localparam int SCL_STG = 4;
	localparam int NSTG    = MAT_STG + DIV_STG + SCL_STG;

	typedef struct packed {
		logic [IN_W-1:0] chroma_x;
		logic [IN_W-1:0] chroma_y;
	} xy_t;

	typedef struct packed {
		logic [OUT_W-1:0] red;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] blue;
	} rgb_t;

	typedef logic [2:0][CW-1:0] chan_t;
	typedef logic [2:0][NW-1:0] frac_t;

endpackage

@@ design/cxr_matrix.sv @@
module cxr_matrix (
	input  logic                      clk,
	input  logic [cxr_pkg::MAT_STG-1:0] en,
	input  cxr_pkg::xy_t              xy,
	output cxr_pkg::chan_t            chan,
	output logic [cxr_pkg::CW-1:0]    peak,
	output logic                      black
);

	localparam logic signed [cxr_pkg::KW-1:0] C_RX = cxr_pkg::KW'(cxr_pkg::K_RX);
	localparam logic signed [cxr_pkg::KW-1:0] C_RY = cxr_pkg::KW'(cxr_pkg::K_RY);
	localparam logic signed [cxr_pkg::KW-1:0] C_RZ = cxr_pkg::KW'(cxr_pkg::K_RZ);
	localparam logic signed [cxr_pkg::KW-1:0] C_GX = cxr_pkg::KW'(cxr_pkg::K_GX);
	localparam logic signed [cxr_pkg::KW-1:0] C_GY = cxr_pkg::KW'(cxr_pkg::K_GY);
	localparam logic signed [cxr_pkg::KW-1:0] C_GZ = cxr_pkg::KW'(cxr_pkg::K_GZ);
	localparam logic signed [cxr_pkg::KW-1:0] C_BX = cxr_pkg::KW'(cxr_pkg::K_BX);
	localparam logic signed [cxr_pkg::KW-1:0] C_BY = cxr_pkg::KW'(cxr_pkg::K_BY);
	localparam logic signed [cxr_pkg::KW-1:0] C_BZ = cxr_pkg::KW'(cxr_pkg::K_BZ);
	localparam logic signed [cxr_pkg::ZW-1:0] ONE_Q =
		cxr_pkg::ZW'(longint'(1) << cxr_pkg::FRAC_BITS);

	logic signed [cxr_pkg::ZW-1:0] xs, ys, zs;
	logic signed [cxr_pkg::PW-1:0] rx_s1, ry_s1, rz_s1, gx_s1, gy_s1, gz_s1;
	logic signed [cxr_pkg::PW-1:0] bx_s1, by_s1, bz_s1;
	logic                          black_s1, black_s2, black_s3;
	logic signed [cxr_pkg::SW-1:0] r_sum, g_sum, b_sum;
	cxr_pkg::chan_t                chan_s2, chan_s3;
	logic [cxr_pkg::CW-1:0]        rg_max, rgb_max, peak_s3;

	// z = 1 - x - y, carried signed
	assign xs = $signed({{(cxr_pkg::ZW-cxr_pkg::IN_W){1'b0}}, xy.chroma_x});
	assign ys = $signed({{(cxr_pkg::ZW-cxr_pkg::IN_W){1'b0}}, xy.chroma_y});
	assign zs = ONE_Q - xs - ys;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rx_s1    <= C_RX * xs;
			ry_s1    <= C_RY * ys;
			rz_s1    <= C_RZ * zs;
			gx_s1    <= C_GX * xs;
			gy_s1    <= C_GY * ys;
			gz_s1    <= C_GZ * zs;
			bx_s1    <= C_BX * xs;
			by_s1    <= C_BY * ys;
			bz_s1    <= C_BZ * zs;
			black_s1 <= (xy.chroma_y == '0);
		end
	end

	assign r_sum = cxr_pkg::SW'(rx_s1) - cxr_pkg::SW'(ry_s1) - cxr_pkg::SW'(rz_s1);
	assign g_sum = cxr_pkg::SW'(gy_s1) - cxr_pkg::SW'(gx_s1) + cxr_pkg::SW'(gz_s1);
	assign b_sum = cxr_pkg::SW'(bx_s1) - cxr_pkg::SW'(by_s1) + cxr_pkg::SW'(bz_s1);

	// clamp negatives to zero
	always_ff @(posedge clk) begin
		if (en[1]) begin
			chan_s2[0] <= r_sum[cxr_pkg::SW-1] ? '0 : r_sum[cxr_pkg::CW-1:0];
			chan_s2[1] <= g_sum[cxr_pkg::SW-1] ? '0 : g_sum[cxr_pkg::CW-1:0];
			chan_s2[2] <= b_sum[cxr_pkg::SW-1] ? '0 : b_sum[cxr_pkg::CW-1:0];
			black_s2   <= black_s1;
		end
	end

	assign rg_max  = (chan_s2[1] > chan_s2[0]) ? chan_s2[1] : chan_s2[0];
	assign rgb_max = (chan_s2[2] > rg_max) ? chan_s2[2] : rg_max;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			chan_s3  <= chan_s2;
			peak_s3  <= rgb_max;
			black_s3 <= black_s2 | (rgb_max == '0);
		end
	end

	assign chan  = chan_s3;
	assign peak  = peak_s3;
	assign black = black_s3;

endmodule

@@ design/cxr_divider.sv @@
module cxr_divider (
	input  logic                        clk,
	input  logic [cxr_pkg::DIV_STG-1:0] en,
	input  cxr_pkg::chan_t              chan,
	input  logic [cxr_pkg::CW-1:0]      peak,
	input  logic                        black,
	output cxr_pkg::frac_t              frac,
	output logic                        black_out
);

	// restoring division, one quotient bit per stage and lane
	cxr_pkg::chan_t         rem_s [cxr_pkg::DIV_STG];
	cxr_pkg::frac_t         quo_s [cxr_pkg::DIV_STG];
	logic [cxr_pkg::CW-1:0] peak_s [cxr_pkg::DIV_STG];
	logic                   black_s [cxr_pkg::DIV_STG];

	for (genvar k = 0; k < cxr_pkg::DIV_STG; k++) begin : g_stage
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[k]) begin
					for (int l = 0; l < 3; l++) begin
						if (chan[l] >= peak) begin
							rem_s[k][l] <= chan[l] - peak;
							quo_s[k][l] <= cxr_pkg::NW'(1);
						end else begin
							rem_s[k][l] <= chan[l];
							quo_s[k][l] <= '0;
						end
					end
					peak_s[k]  <= peak;
					black_s[k] <= black;
				end
			end
		end else begin : g_next
			logic [2:0][cxr_pkg::CW:0] dbl;
			always_comb begin
				for (int l = 0; l < 3; l++)
					dbl[l] = {rem_s[k-1][l], 1'b0};
			end
			always_ff @(posedge clk) begin
				if (en[k]) begin
					for (int l = 0; l < 3; l++) begin
						if (dbl[l] >= {1'b0, peak_s[k-1]}) begin
							rem_s[k][l] <= cxr_pkg::CW'(dbl[l] - {1'b0, peak_s[k-1]});
							quo_s[k][l] <= {quo_s[k-1][l][cxr_pkg::NW-2:0], 1'b1};
						end else begin
							rem_s[k][l] <= dbl[l][cxr_pkg::CW-1:0];
							quo_s[k][l] <= {quo_s[k-1][l][cxr_pkg::NW-2:0], 1'b0};
						end
					end
					peak_s[k]  <= peak_s[k-1];
					black_s[k] <= black_s[k-1];
				end
			end
		end
	end

	assign frac      = quo_s[cxr_pkg::DIV_STG-1];
	assign black_out = black_s[cxr_pkg::DIV_STG-1];

endmodule

@@ design/cxr_scale.sv @@
module cxr_scale (
	input  logic                        clk,
	input  logic [cxr_pkg::SCL_STG-1:0] en,
	input  cxr_pkg::frac_t              frac,
	input  logic                        black,
	input  logic [cxr_pkg::BRT_W-1:0]   brightness,
	output cxr_pkg::rgb_t               rgb
);

	localparam int QW = cxr_pkg::TW + 9;

	logic [2:0][cxr_pkg::PB_W-1:0] prod_s1;
	logic [2:0][cxr_pkg::TW-1:0]   t_s2, t_s3;
	logic [2:0][cxr_pkg::TW-1:0]   q_s3;
	logic [2:0][cxr_pkg::TW-1:0]   q_fix;
	logic [2:0][cxr_pkg::TW-1:0]   r_fix;
	logic [2:0][cxr_pkg::AW-1:0]   acc;
	logic [2:0][QW-1:0]            qprod;
	logic [2:0][cxr_pkg::OUT_W-1:0] drv_s4;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int l = 0; l < 3; l++)
				prod_s1[l] <= black ? '0 :
					cxr_pkg::PB_W'(frac[l]) * cxr_pkg::PB_W'(brightness);
		end
	end

	// (p * full + d/2) >> frac_bits, then a divide by 255
	always_comb begin
		for (int l = 0; l < 3; l++)
			acc[l] = cxr_pkg::AW'(prod_s1[l]) * cxr_pkg::AW'(cxr_pkg::OUT_FULL)
				+ cxr_pkg::AW'(cxr_pkg::HALF_DEN);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int l = 0; l < 3; l++)
				t_s2[l] <= acc[l][cxr_pkg::AW-1:cxr_pkg::FRAC_BITS];
		end
	end

	// reciprocal estimate is exact or one low
	always_comb begin
		for (int l = 0; l < 3; l++)
			qprod[l] = QW'(t_s2[l]) * QW'(cxr_pkg::RECIP);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int l = 0; l < 3; l++) begin
				q_s3[l] <= cxr_pkg::TW'(qprod[l] >> cxr_pkg::RECIP_SH);
				t_s3[l] <= t_s2[l];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			r_fix[l] = t_s3[l] - cxr_pkg::TW'(q_s3[l] * cxr_pkg::TW'(255));
			q_fix[l] = (r_fix[l] >= cxr_pkg::TW'(255)) ? q_s3[l] + 1'b1 : q_s3[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int l = 0; l < 3; l++)
				drv_s4[l] <= cxr_pkg::OUT_W'(q_fix[l] & cxr_pkg::TW'(cxr_pkg::OUT_FULL));
		end
	end

	assign rgb.red   = drv_s4[0];
	assign rgb.green = drv_s4[1];
	assign rgb.blue  = drv_s4[2];

endmodule

@@ design/cie_xy_to_rgb_converter.sv @@
// channel | direction | payload                         | handshake
// in      | in        | xy_t: chroma_x, chroma_y        | in_valid / in_ready
// out     | out       | rgb_t: red, green, blue         | out_valid / out_ready
// cfg     | in        | brightness_level, 8 bits        | cfg_valid / cfg_ready
//
// one transaction per cycle sustained while out_ready is held high; the normalizing divider
// produces one quotient bit per stage
// arst_n clears all stage valid bits and sets brightness to 255
// a stall at the output holds only the stages behind a full stage: bubbles close up
// cfg is always ready; write it only while the pipeline is empty
module cie_xy_to_rgb_converter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  cxr_pkg::xy_t              in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output cxr_pkg::rgb_t             out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cxr_pkg::BRT_W-1:0] cfg_data
);

	localparam int DIV_LO = cxr_pkg::MAT_STG;
	localparam int SCL_LO = cxr_pkg::MAT_STG + cxr_pkg::DIV_STG;

	logic [cxr_pkg::NSTG-1:0]  valid_q;
	logic [cxr_pkg::NSTG-1:0]  en;
	logic [cxr_pkg::BRT_W-1:0] brightness_q;

	cxr_pkg::chan_t            chan;
	logic [cxr_pkg::CW-1:0]    peak;
	logic                      mat_black;
	cxr_pkg::frac_t            frac;
	logic                      div_black;

	// brightness register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= '1;
		end else if (cfg_valid) begin
			brightness_q <= cfg_data;
		end
	end

	// a stage loads when it is empty or its content moves on
	always_comb begin
		en[cxr_pkg::NSTG-1] = !valid_q[cxr_pkg::NSTG-1] || out_ready;
		for (int i = cxr_pkg::NSTG - 2; i >= 0; i--)
			en[i] = !valid_q[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0])
				valid_q[0] <= in_valid;
			for (int i = 1; i < cxr_pkg::NSTG; i++) begin
				if (en[i])
					valid_q[i] <= valid_q[i-1];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = valid_q[cxr_pkg::NSTG-1];

	// matrix, clamp and peak channel
	cxr_matrix u_matrix (
		.clk   (clk),
		.en    (en[cxr_pkg::MAT_STG-1:0]),
		.xy    (in_data),
		.chan  (chan),
		.peak  (peak),
		.black (mat_black)
	);

	// each channel over the peak, in Q(FRAC_BITS)
	cxr_divider u_divider (
		.clk       (clk),
		.en        (en[SCL_LO-1:DIV_LO]),
		.chan      (chan),
		.peak      (peak),
		.black     (mat_black),
		.frac      (frac),
		.black_out (div_black)
	);

	// brightness scaling and rounding to drive values
	cxr_scale u_scale (
		.clk        (clk),
		.en         (en[cxr_pkg::NSTG-1:SCL_LO]),
		.frac       (frac),
		.black      (div_black),
		.brightness (brightness_q),
		.rgb        (out_data)
	);

endmodule

@@ sim/tb_cie_xy_to_rgb_converter.sv @@
module tb_cie_xy_to_rgb_converter;
	import cxr_pkg::*;

	// pipeline depth, used with a margin for drain waits
	localparam int LATENCY = 3 + (FRAC_BITS + 1) + 4;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	xy_t in_data;
	logic out_valid;
	logic out_ready;
	rgb_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [BRT_W-1:0] cfg_data;

	// chromaticity items waiting to be offered, expected results of accepted items, and the brightness in force
	xy_t pending_xy[$];
	rgb_t expected_rgb[$];
	logic [BRT_W-1:0] brightness;
	int n_errors = 0;

	// receiver control: idle percentage and a long hold-off counter; sender idle percentage and pause
	int sink_idle_pct = 15;
	int sink_hold = 0;
	int src_idle_pct = 15;
	bit src_pause = 0;

	cie_xy_to_rgb_converter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// rounded drive value from a Q16 fraction and the brightness
	function automatic logic [7:0] drive_level(longint unsigned frac, longint unsigned brt);
		longint unsigned v;
		v = frac * brt * 255;
		v = (v + (longint'(255) << 15)) / (longint'(255) << 16);
		return v[7:0];
	endfunction

	// floor(c * 2^16 / m), c <= m
	function automatic longint unsigned chan_fraction(longint unsigned c, longint unsigned m);
		return (c << FRAC_BITS) / m;
	endfunction

	// srgb conversion of one chromaticity at a given brightness
	function automatic rgb_t xy_to_rgb(xy_t p, logic [BRT_W-1:0] brt);
		longint sx, sy, sz, rs, gs, bs;
		longint unsigned r, g, b, m;
		rgb_t res;
		res = '0;
		sx = longint'(p.chroma_x);
		sy = longint'(p.chroma_y);
		if (sy == 0) return res;
		sz = (longint'(1) << FRAC_BITS) - sx - sy;
		rs = K_RX * sx - K_RY * sy - K_RZ * sz;
		gs = -K_GX * sx + K_GY * sy + K_GZ * sz;
		bs = K_BX * sx - K_BY * sy + K_BZ * sz;
		r = (rs < 0) ? 0 : rs;
		g = (gs < 0) ? 0 : gs;
		b = (bs < 0) ? 0 : bs;
		m = r;
		if (g > m) m = g;
		if (b > m) m = b;
		if (m == 0) return res;
		res.red   = drive_level(chan_fraction(r, m), brt);
		res.green = drive_level(chan_fraction(g, m), brt);
		res.blue  = drive_level(chan_fraction(b, m), brt);
		return res;
	endfunction

	// input driver: offers the queue head, holds it until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_rgb.push_back(xy_to_rgb(in_data, brightness));
				void'(pending_xy.pop_front());
			end
			if (in_valid && !in_ready) begin
				// keep offering the same transaction
			end else if (pending_xy.size() > 0 && !src_pause
					&& $urandom_range(99) >= src_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_xy[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output monitor with random and long stalls
	always @(posedge clk or negedge arst_n) begin
		rgb_t exp_v;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_rgb.size() == 0) begin
					$error("unexpected transaction %h", out_data);
					n_errors++;
				end else begin
					exp_v = expected_rgb.pop_front();
					if (out_data.red !== exp_v.red) begin
						$error("red expected %0d actual %0d", exp_v.red, out_data.red);
						n_errors++;
					end
					if (out_data.green !== exp_v.green) begin
						$error("green expected %0d actual %0d", exp_v.green, out_data.green);
						n_errors++;
					end
					if (out_data.blue !== exp_v.blue) begin
						$error("blue expected %0d actual %0d", exp_v.blue, out_data.blue);
						n_errors++;
					end
				end
			end
			if (sink_hold > 0) begin
				sink_hold <= sink_hold - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	task automatic wait_drained();
		while (pending_xy.size() != 0 || in_valid || expected_rgb.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// configuration write while the pipeline is empty
	task automatic write_level(logic [BRT_W-1:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		brightness = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic xy_t mk_xy(int x, int y);
		xy_t p;
		p.chroma_x = IN_W'(x);
		p.chroma_y = IN_W'(y);
		return p;
	endfunction

	// mostly realistic chromaticities, some anywhere in the field range
	function automatic xy_t rand_xy();
		int x, y;
		if ($urandom_range(9) < 7) begin
			x = $urandom_range(65536);
			y = $urandom_range(65536 - x);
		end else begin
			x = $urandom_range(131071);
			y = $urandom_range(131071);
		end
		if ($urandom_range(49) == 0) y = 0;
		return mk_xy(x, y);
	endfunction

	initial begin
		logic [BRT_W-1:0] levels[6];
		levels[0] = BRT_W'(255);
		levels[1] = BRT_W'(0);
		levels[2] = BRT_W'(1);
		levels[3] = BRT_W'(128);
		levels[4] = BRT_W'(200);
		levels[5] = BRT_W'(254);
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		brightness = BRT_W'(255);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners: black cases, primaries, white, out-of-range sums
		pending_xy.push_back(mk_xy(0, 0));
		pending_xy.push_back(mk_xy(65536, 0));
		pending_xy.push_back(mk_xy(0, 65536));
		pending_xy.push_back(mk_xy(65536, 65536));
		pending_xy.push_back(mk_xy(131071, 131071));
		pending_xy.push_back(mk_xy(131071, 1));
		pending_xy.push_back(mk_xy(1, 131071));
		pending_xy.push_back(mk_xy(20493, 21561));
		pending_xy.push_back(mk_xy(41943, 21627));
		pending_xy.push_back(mk_xy(19661, 39322));
		pending_xy.push_back(mk_xy(9830, 3932));
		pending_xy.push_back(mk_xy(0, 1));
		pending_xy.push_back(mk_xy(1, 1));
		pending_xy.push_back(mk_xy(65535, 1));
		pending_xy.push_back(mk_xy(43690, 43690));
		pending_xy.push_back(mk_xy(85000, 30000));

		// walk through the brightness settings with random traffic
		for (int s = 0; s < 6; s++) begin
			write_level(levels[s]);
			pending_xy.push_back(mk_xy(20493, 21561));
			for (int i = 0; i < 260; i++) pending_xy.push_back(rand_xy());
			if (s == 2) begin
				// long stall on the output so the pipeline backs up
				wait (pending_xy.size() < 200);
				sink_hold = 300;
			end
			if (s == 3) begin
				// no idling on either side for a while
				sink_idle_pct = 0;
				src_idle_pct = 0;
				wait (pending_xy.size() == 0);
				sink_idle_pct = 15;
				src_idle_pct = 15;
			end
			if (s == 4) begin
				// sender pauses until every result is back
				wait (pending_xy.size() < 130);
				src_pause = 1;
				@(posedge clk);
				while (in_valid || expected_rgb.size() != 0) @(posedge clk);
				src_pause = 0;
			end
		end
		write_level(BRT_W'(255));
		for (int i = 0; i < 100; i++) pending_xy.push_back(rand_xy());
		wait_drained();

		if (n_errors == 0)
			$display("cie_xy_to_rgb_converter test passed");
		else
			$display("cie_xy_to_rgb_converter test failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("cie_xy_to_rgb_converter test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
design/cxr_pkg.sv
design/cxr_matrix.sv
design/cxr_divider.sv
design/cxr_scale.sv
design/cie_xy_to_rgb_converter.sv
sim/tb_cie_xy_to_rgb_converter.sv
